### hw/rtl/rfid_access_lock_controller_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the card lock controller
// Clocked on clock, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef RFID_ACCESS_LOCK_CONTROLLER_ASSERT_SVH
`define RFID_ACCESS_LOCK_CONTROLLER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define RALC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define RALC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/ralc_pkg.sv
// ----------------------------------------------------------------------------
// ralc_pkg
// Types and constants shared by the card lock controller and its key cells.
// ----------------------------------------------------------------------------
package ralc_pkg;

   localparam int UID_W    = 32;
   localparam int LEVEL_W  = 10;
   localparam int RESULT_W = 3;
   localparam int PULSE_W  = 3;
   localparam int COUNT_W  = 3;
   localparam int TICK_W   = 8;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [LEVEL_W-1:0] PRESSED_LEVEL = 10'd1023;
   localparam logic [PULSE_W-1:0] REJECT_PULSES    = 3'd5;
   localparam logic [PULSE_W-1:0] INTRUSION_PULSES = 3'd1;
   localparam logic [UID_W-1:0]   MASTER_RESET = 32'h635D62A7;
   localparam logic [TICK_W-1:0]  LIMIT_RESET  = 8'd50;

   localparam logic [RESULT_W-1:0] RES_NONE     = 3'd0;
   localparam logic [RESULT_W-1:0] RES_ACCEPTED = 3'd1;
   localparam logic [RESULT_W-1:0] RES_REJECTED = 3'd2;
   localparam logic [RESULT_W-1:0] RES_ENROLLED = 3'd3;
   localparam logic [RESULT_W-1:0] RES_KNOWN    = 3'd4;
   localparam logic [RESULT_W-1:0] RES_FULL     = 3'd5;

   // register index is address bit 2
   localparam logic REG_MASTER_KEY      = 1'b0;
   localparam logic REG_INTRUSION_LIMIT = 1'b1;

   // lookup travelling along the key cells
   typedef struct packed {
      logic             valid;
      logic             hit;
      logic [UID_W-1:0] uid;
   } probe_type;

endpackage

### hw/rtl/ralc_key_cell.sv
// ----------------------------------------------------------------------------
// ralc_key_cell
// One enrolled key slot: compares the passing lookup and hands it on.
// ----------------------------------------------------------------------------
module ralc_key_cell import ralc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             active,
   input  logic             wr_en,
   input  logic [UID_W-1:0] wr_key,
   input  probe_type        probe_in,
   output probe_type        probe_out
);

   logic [UID_W-1:0] key_ff;
   logic             valid_ff;
   logic             hit_ff;
   logic [UID_W-1:0] uid_ff;
   logic             hit_in;

   assign hit_in = probe_in.hit | (active & (key_ff == probe_in.uid));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_ff <= wr_key;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= probe_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      hit_ff <= hit_in;
      uid_ff <= probe_in.uid;
   end

   assign probe_out.valid = valid_ff;
   assign probe_out.hit   = hit_ff;
   assign probe_out.uid   = uid_ff;

endmodule

### hw/rtl/rfid_access_lock_controller.sv
// Path: an accepted item walks the key cells, then the chain-end capture register, then the
// decision stage, which fills the output register and raises rsp_valid once it is free
// (the master compare rides with the accept). Only one item is in flight at a time; the next item
// is taken once the result sits in the output register.
// Reset: synchronous; locked, no keys enrolled, registers back to default values.
// ----------------------------------------------------------------------------
// rfid_access_lock_controller
// Card lock: key lookup along a row of key cells, enrolment, light supervision.
// ----------------------------------------------------------------------------
module rfid_access_lock_controller import ralc_pkg::*; #(
   parameter int MAX_KEYS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_card_present,
   input  logic [UID_W-1:0]      req_card_id,
   input  logic [LEVEL_W-1:0]    req_add_level,
   input  logic [LEVEL_W-1:0]    req_photo_level,
   input  logic [LEVEL_W-1:0]    req_light_reference,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [RESULT_W-1:0]   rsp_card_result,
   output logic                  rsp_armed,
   output logic                  rsp_intrusion,
   output logic [PULSE_W-1:0]    rsp_buzzer_pulses,
   output logic                  rsp_is_locked,
   output logic                  rsp_door_opened,
   output logic [COUNT_W-1:0]    rsp_enrolled_count,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int NK = MAX_KEYS - 1;
   localparam int CW = $clog2(MAX_KEYS);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [UID_W-1:0]  master_key_ff;
   logic [TICK_W-1:0] limit_ff;
   logic [CW-1:0]     key_count_ff, key_count_in;
   logic              lock_ff, lock_in;
   logic              open_ff, open_in;
   logic [TICK_W-1:0] ticks_ff, ticks_in;

   logic              present_ff;
   logic              pressed_ff;
   logic              lit_ff;
   logic              hit_ff;
   logic [UID_W-1:0]  uid_ff;

   logic                rsp_valid_ff;
   logic [RESULT_W-1:0] result_ff, result_in;
   logic                armed_ff, armed_in;
   logic                intrusion_ff, intrusion_in;
   logic [PULSE_W-1:0]  pulses_ff, pulses_in;

   probe_type chain [NK+1];

   logic accept, slot_free, finish, csr_we;
   logic enroll, full, enroll_we, lock_mid, open_mid;
   logic [TICK_W-1:0] ticks_inc;

   // ---------------------------------------------------------------- csr
   assign pready = 1'b1;
   assign csr_we = psel & penable & pwrite;
   assign prdata = (paddr[2] == REG_INTRUSION_LIMIT) ?
                   {{(CSR_DATA_W-TICK_W){1'b0}}, limit_ff} : master_key_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         master_key_ff <= MASTER_RESET;
         limit_ff      <= LIMIT_RESET;
      end else if (csr_we) begin
         if (paddr[2] == REG_MASTER_KEY) begin
            master_key_ff <= pwdata;
         end else begin
            limit_ff <= pwdata[TICK_W-1:0];
         end
      end
   end

   // ---------------------------------------------------------------- control
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;
   assign slot_free = ~rsp_valid_ff | rsp_ready;
   assign finish    = (state_ff == ST_DONE) & slot_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (chain[NK].valid) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // master compare enters with the lookup
   assign chain[0].valid = accept;
   assign chain[0].hit   = (req_card_id == master_key_ff);
   assign chain[0].uid   = req_card_id;

   always_ff @(posedge clock) begin
      if (accept) begin
         present_ff <= req_card_present;
         pressed_ff <= (req_add_level == PRESSED_LEVEL);
         lit_ff     <= (req_photo_level < req_light_reference);
      end
      if (chain[NK].valid) begin
         hit_ff <= chain[NK].hit;
         uid_ff <= chain[NK].uid;
      end
   end

   // ---------------------------------------------------------------- key cells
   for (genvar i = 0; i < NK; i++) begin : g_cell
      ralc_key_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .active    (CW'(i) < key_count_ff),
         .wr_en     (finish & enroll_we & (key_count_ff == CW'(i))),
         .wr_key    (uid_ff),
         .probe_in  (chain[i]),
         .probe_out (chain[i+1])
      );
   end

   // ---------------------------------------------------------------- decision
   assign enroll = ~lock_ff & pressed_ff;
   assign full   = (key_count_ff == CW'(NK));

   always_comb begin
      result_in    = RES_NONE;
      pulses_in    = '0;
      enroll_we    = 1'b0;
      lock_mid     = lock_ff;
      open_mid     = open_ff;
      key_count_in = key_count_ff;
      if (present_ff) begin
         if (enroll) begin
            if (hit_ff) begin
               result_in = RES_KNOWN;
            end else if (full) begin
               result_in = RES_FULL;
            end else begin
               result_in    = RES_ENROLLED;
               enroll_we    = 1'b1;
               key_count_in = key_count_ff + CW'(1);
            end
         end else if (hit_ff) begin
            result_in = RES_ACCEPTED;
            lock_mid  = 1'b0;
            open_mid  = 1'b0;
         end else begin
            result_in = RES_REJECTED;
            lock_mid  = 1'b1;
            pulses_in = REJECT_PULSES;
         end
      end

      lock_in  = lock_mid;
      open_in  = open_mid;
      armed_in = 1'b0;
      if (lit_ff & ~lock_mid) begin
         open_in = 1'b1;
      end
      if (~lit_ff & ~lock_mid & open_mid) begin
         open_in  = 1'b0;
         lock_in  = 1'b1;
         armed_in = 1'b1;
      end

      ticks_inc    = (lit_ff & lock_in) ? ticks_ff + TICK_W'(1) : '0;
      intrusion_in = lit_ff & lock_in & (ticks_inc == limit_ff);
      ticks_in     = intrusion_in ? '0 : ticks_inc;
      if (intrusion_in) begin
         pulses_in = pulses_in + INTRUSION_PULSES;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         key_count_ff <= '0;
         lock_ff      <= 1'b1;
         open_ff      <= 1'b0;
         ticks_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (finish) begin
            key_count_ff <= key_count_in;
            lock_ff      <= lock_in;
            open_ff      <= open_in;
            ticks_ff     <= ticks_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         result_ff    <= result_in;
         armed_ff     <= armed_in;
         intrusion_ff <= intrusion_in;
         pulses_ff    <= pulses_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_card_result    = result_ff;
   assign rsp_armed          = armed_ff;
   assign rsp_intrusion      = intrusion_ff;
   assign rsp_buzzer_pulses  = pulses_ff;
   assign rsp_is_locked      = lock_ff;
   assign rsp_door_opened    = open_ff;
   assign rsp_enrolled_count = COUNT_W'(key_count_ff);

   // ---------------------------------------------------------------- checks
`include "rfid_access_lock_controller_assert.svh"

   `RALC_ASSERT_NOW(a_count_range, 1'b1, key_count_ff <= CW'(NK), "key count beyond table")
   `RALC_ASSERT_NEXT(a_accept_scan, accept, state_ff == ST_SCAN, "accepted item not scanning")
   `RALC_ASSERT_NOW(a_exit_scan, chain[NK].valid, state_ff == ST_SCAN, "stray lookup at chain end")
   `RALC_ASSERT_NOW(a_intr_locked, rsp_valid_ff && intrusion_ff, lock_ff, "intrusion while unlocked")
   `RALC_ASSERT_NOW(a_reject_locked, rsp_valid_ff && result_ff == RES_REJECTED, lock_ff,
      "rejected card left lock open")

endmodule
